// File: hw/rtl/phti_pkg.sv
package phti_pkg;

    localparam int unsigned StampW = 48;
    localparam int unsigned PosW   = 32;
    localparam int unsigned YawW   = 16;
    localparam int unsigned LamW   = 16;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_EMPTY   = 3'd0,
        ST_TOO_NEW = 3'd1,
        ST_TO_NOW  = 3'd2,
        ST_OLDEST  = 3'd3,
        ST_BETWEEN = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [StampW-1:0]        entry_stamp;
        logic signed [PosW-1:0]   entry_x;
        logic signed [PosW-1:0]   entry_y;
        logic signed [YawW-1:0]   entry_yaw;
        logic [StampW-1:0]        query_time;
        logic [StampW-1:0]        now_time;
    } t_in_word;

    typedef struct packed {
        logic signed [PosW-1:0]   pose_x;
        logic signed [PosW-1:0]   pose_y;
        logic signed [YawW-1:0]   pose_yaw;
        logic [2:0]               status;
    } t_out_word;

    // Queue word from the front part: a query, the time pair
    typedef struct packed {
        logic [StampW-1:0]        query_time;
        logic [StampW-1:0]        now_time;
    } t_job;

    typedef struct packed {
        logic [StampW-1:0]        stamp;
        logic signed [PosW-1:0]   x;
        logic signed [PosW-1:0]   y;
        logic signed [YawW-1:0]   yaw;
    } t_entry;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_READ,
        BK_CHECK,
        BK_PREV,
        BK_PREV_WAIT,
        BK_START,
        BK_DIV,
        BK_MUL,
        BK_SUM,
        BK_OUT
    } t_bk_state;

endpackage

// File: hw/rtl/phti_front.sv
module phti_front #(
    parameter int unsigned CntW = 9,
    parameter int unsigned Depth = 256,
    parameter int unsigned AddrW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  phti_pkg::t_in_word   i_data,
    input  logic                 i_back_busy,
    output logic                 o_wr_en,
    output logic [AddrW-1:0]     o_wr_addr,
    output phti_pkg::t_entry     o_wr_data,
    output logic [CntW-1:0]      o_count,
    output logic                 o_job_valid,
    output phti_pkg::t_job       o_job,
    input  logic                 i_job_take
);
    import phti_pkg::*;

    logic [CntW-1:0] r_count;
    logic            r_job_valid;
    t_job            r_job;
    logic            accept;
    t_cmd            cmd;

    assign cmd = t_cmd'(i_data.cmd);
    // Hold history changes while a query is still queued or running
    assign o_stall = r_job_valid || i_back_busy;
    assign accept  = i_valid && !o_stall;

    assign o_wr_en   = accept && (cmd == CMD_APPEND) && (r_count < CntW'(Depth));
    assign o_wr_addr = r_count[AddrW-1:0];
    assign o_wr_data = '{stamp: i_data.entry_stamp, x: i_data.entry_x,
                         y: i_data.entry_y, yaw: i_data.entry_yaw};
    assign o_count     = r_count;
    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_job_valid <= 1'b0;
        end else begin
            if (i_job_take) begin
                r_job_valid <= 1'b0;
            end
            if (accept) begin
                unique case (cmd)
                    CMD_CLEAR:  r_count <= '0;
                    CMD_APPEND: if (o_wr_en) begin
                        r_count <= r_count + 1'b1;
                    end
                    CMD_QUERY:  r_job_valid <= 1'b1;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && cmd == CMD_QUERY) begin
            r_job <= '{query_time: i_data.query_time, now_time: i_data.now_time};
        end
    end
endmodule

// File: hw/rtl/phti_div.sv
module phti_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_num,
    input  logic [47:0] i_den,
    output logic        o_done,
    output logic [15:0] o_lam
);
    // Restoring division of num*65536 by den; quotient saturated to 16 bits
    logic [63:0] r_rem;
    logic [47:0] r_num;
    logic [47:0] r_den;
    logic [16:0] r_q;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_big;
    logic [64:0] trial;
    logic [63:0] shifted;

    assign shifted = {r_rem[62:0], r_num[47]};
    assign trial   = {1'b0, shifted} - {17'd0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_rem  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_q    <= '0;
                r_big  <= 1'b0;
            end else if (r_busy) begin
                r_num <= {r_num[46:0], 1'b0};
                if (!trial[64]) begin
                    r_rem <= trial[63:0];
                end else begin
                    r_rem <= shifted;
                end
                if (!trial[64] && r_cnt > 7'd16) begin
                    r_big <= 1'b1;
                end
                r_q <= {r_q[15:0], ~trial[64]};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_lam = (r_big || r_q[16]) ? 16'hFFFF : r_q[15:0];
endmodule

// File: hw/rtl/phti_back.sv
module phti_back #(
    parameter int unsigned CntW = 9,
    parameter int unsigned Depth = 256,
    parameter int unsigned AddrW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [AddrW-1:0]     i_wr_addr,
    input  phti_pkg::t_entry     i_wr_data,
    input  logic [CntW-1:0]      i_count,
    input  logic                 i_job_valid,
    input  phti_pkg::t_job       i_job,
    output logic                 o_job_take,
    output logic                 o_busy,
    output logic                 o_valid,
    input  logic                 i_stall,
    output phti_pkg::t_out_word  o_data
);
    import phti_pkg::*;

    t_entry          r_mem [Depth];
    t_entry          r_rd;
    logic [AddrW-1:0] rd_addr;
    logic            rd_en;

    t_bk_state       r_state, n_state;
    logic [CntW-1:0] r_idx;
    t_job            r_job;
    t_entry          r_older, r_newer;
    logic [2:0]      r_status;
    logic [15:0]     r_lam;
    logic signed [48:0] r_px2, r_px1, r_py2, r_py1;
    logic signed [32:0] r_pyaw;
    logic            r_out_valid;
    t_out_word       r_out;
    logic            div_start, div_done;
    logic [15:0]     div_lam;
    logic [47:0]     div_num, div_den;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    assign div_num = r_job.query_time - r_older.stamp;
    assign div_den = r_newer.stamp - r_older.stamp;

    phti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_lam   (div_lam)
    );

    logic [16:0]        inv_lam;
    logic signed [15:0] yaw_d;
    logic signed [48:0] sum_x, sum_y;
    logic signed [32:0] yaw_step;
    logic [15:0]        yaw_out;

    assign inv_lam = 17'h10000 - {1'b0, r_lam};
    assign yaw_d   = r_newer.yaw - r_older.yaw;
    assign sum_x   = r_px2 + r_px1 + 49'sd32768;
    assign sum_y   = r_py2 + r_py1 + 49'sd32768;
    assign yaw_step = r_pyaw + 33'sd32768;
    assign yaw_out = r_older.yaw + yaw_step[31:16];

    always_comb begin
        n_state    = r_state;
        rd_en      = 1'b0;
        rd_addr    = r_idx[AddrW-1:0];
        o_job_take = 1'b0;
        div_start  = 1'b0;
        unique case (r_state)
            BK_IDLE: if (i_job_valid && !r_out_valid) begin
                o_job_take = 1'b1;
                n_state = BK_READ;
            end
            BK_READ: begin
                // Empty history needs no scan
                if (i_count == '0) begin
                    n_state = BK_OUT;
                end else begin
                    rd_en = 1'b1;
                    n_state = BK_CHECK;
                end
            end
            BK_CHECK: begin
                if (r_rd.stamp <= r_job.query_time) begin
                    if (r_idx == '0) begin
                        n_state = (r_job.query_time >= r_job.now_time) ? BK_OUT : BK_START;
                    end else begin
                        rd_en = 1'b1;
                        rd_addr = AddrW'(r_idx - 1'b1);
                        n_state = BK_PREV_WAIT;
                    end
                end else if (r_idx + 1'b1 >= i_count) begin
                    n_state = BK_OUT;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = AddrW'(r_idx + 1'b1);
                end
            end
            BK_PREV_WAIT: n_state = BK_PREV;
            BK_PREV: n_state = BK_START;
            // Load the divider once both endpoints sit in registers
            BK_START: begin
                div_start = 1'b1;
                n_state = BK_DIV;
            end
            BK_DIV: if (div_done) begin
                n_state = BK_MUL;
            end
            BK_MUL: n_state = BK_SUM;
            BK_SUM: n_state = BK_OUT;
            BK_OUT: n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == BK_OUT) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BK_IDLE: begin
                r_job <= i_job;
                // Hold the waiting word until a new query starts
                if (o_job_take) begin
                    r_idx <= '0;
                    r_status <= ST_EMPTY;
                    r_out <= '0;
                end
            end
            BK_READ: ;
            BK_CHECK: begin
                r_older <= r_rd;
                if (r_rd.stamp <= r_job.query_time) begin
                    if (r_idx == '0) begin
                        r_newer <= '{stamp: r_job.now_time, x: '0, y: '0, yaw: '0};
                        r_status <= (r_job.query_time >= r_job.now_time) ?
                                    ST_TOO_NEW : ST_TO_NOW;
                    end else begin
                        r_status <= ST_BETWEEN;
                    end
                end else if (r_idx + 1'b1 >= i_count) begin
                    r_status <= ST_OLDEST;
                    r_out <= '{pose_x: r_rd.x, pose_y: r_rd.y, pose_yaw: r_rd.yaw,
                               status: ST_OLDEST};
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            BK_PREV_WAIT: ;
            BK_PREV: r_newer <= r_rd;
            BK_START: ;
            BK_DIV: r_lam <= div_lam;
            BK_MUL: begin
                r_px2  <= r_newer.x * $signed({1'b0, r_lam});
                r_px1  <= r_older.x * $signed({1'b0, inv_lam});
                r_py2  <= r_newer.y * $signed({1'b0, r_lam});
                r_py1  <= r_older.y * $signed({1'b0, inv_lam});
                r_pyaw <= yaw_d * $signed({1'b0, r_lam});
            end
            BK_SUM: begin
                r_out <= '{pose_x: sum_x[47:16], pose_y: sum_y[47:16],
                           pose_yaw: yaw_out, status: r_status};
            end
            BK_OUT: if (r_status == ST_TOO_NEW || r_status == ST_EMPTY) begin
                r_out <= '{pose_x: '0, pose_y: '0, pose_yaw: '0, status: r_status};
            end
            default: ;
        endcase
    end

    assign o_busy  = (r_state != BK_IDLE) || r_out_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
endmodule

// File: hw/rtl/pose_history_time_interpolator_top.sv
// Query path: the entries are scanned one by one, then the 64-step divider,
// multiply and sum run; empty, too-new and oldest cases skip the divider.
// Clear and append give no word.
// Throughput: one query at a time, set by the entry scan over the single
// memory read port and the bit-serial divider. Synchronous active-low reset
// empties the history; stored entries are not cleared.
module pose_history_time_interpolator_top #(
    parameter int unsigned HISTORY_DEPTH = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  phti_pkg::t_in_word   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output phti_pkg::t_out_word  o_data
);
    import phti_pkg::*;

    localparam int unsigned AddrW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned CntW  = $clog2(HISTORY_DEPTH + 1);

    logic             wr_en, job_valid, job_take, back_busy;
    logic [AddrW-1:0] wr_addr;
    t_entry           wr_data;
    logic [CntW-1:0]  count;
    t_job             job;

    phti_front #(.CntW(CntW), .Depth(HISTORY_DEPTH), .AddrW(AddrW)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .i_back_busy (back_busy),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_count     (count),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_take  (job_take)
    );

    phti_back #(.CntW(CntW), .Depth(HISTORY_DEPTH), .AddrW(AddrW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_count     (count),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_take  (job_take),
        .o_busy      (back_busy),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );
endmodule

// File: hw/rtl/phti_checker.sv
module phti_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input phti_pkg::t_in_word   i_data,
    input logic                 o_valid,
    input logic                 i_stall,
    input phti_pkg::t_out_word  o_data
);
    import phti_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output word changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.status <= ST_BETWEEN)
        else $error("bad status");

    a_zero_pose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status == ST_EMPTY || o_data.status == ST_TOO_NEW)
        |-> o_data.pose_x == '0 && o_data.pose_y == '0 && o_data.pose_yaw == '0)
        else $error("nonzero pose for empty or too-new");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while a result waits");
endmodule

bind pose_history_time_interpolator_top phti_checker u_phti_checker (.*);
